@@ design/min_max_heap_priority_queue_assert.svh @@
// ----------------------------------------------------------------------------
// min_max_heap_priority_queue_assert
// Assertion macros shared by the min-max heap priority queue.
// ----------------------------------------------------------------------------
`ifndef MIN_MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MIN_MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define MMHPQ_AST_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mmhpq check failed");

// antecedent implies consequent in the following cycle
`define MMHPQ_AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mmhpq check failed");

`endif

@@ design/mmhpq_pkg.sv @@
// ----------------------------------------------------------------------------
// mmhpq_pkg
// Types, constants and helper functions of the min-max heap priority queue.
// ----------------------------------------------------------------------------
package mmhpq_pkg;

  localparam int CAPACITY = 1023;
  localparam int PRIO_W   = 31;
  localparam int TAG_W    = 16;
  localparam int COUNT_W  = 10;
  localparam int ADDR_W   = 10;
  localparam int CAND_W   = ADDR_W + 2;
  localparam int NUM_CAND = 6;

  // request codes
  localparam logic [1:0] REQ_INSERT  = 2'd0;
  localparam logic [1:0] REQ_POP_MIN = 2'd1;
  localparam logic [1:0] REQ_POP_MAX = 2'd2;
  localparam logic [1:0] REQ_UNUSED  = 2'd3;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [PRIO_W-1:0] priority_req;
    logic [TAG_W-1:0]  tag;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [PRIO_W-1:0]  popped_priority;
    logic [TAG_W-1:0]   popped_tag;
    logic [COUNT_W-1:0] entry_count;
    logic [PRIO_W-1:0]  current_min;
    logic [PRIO_W-1:0]  current_max;
    logic               is_empty;
  } rsp_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_cmd_t;

  typedef enum logic [4:0] {
    S_IDLE, S_UP_PAR, S_UP_GP, S_UP_GC, S_WR_FIN,
    S_POP_M2, S_POP_M3, S_POP_TAKE, S_POP_LAST,
    S_TD_SCAN, S_TD_DEC, S_TD_PAR,
    S_FIN, S_F1, S_F2, S_F3, S_RES
  } state_t;

  // true when the position sits on a min level (even tree level)
  function automatic logic on_min_level(input logic [ADDR_W-1:0] pos);
    logic [$clog2(ADDR_W)-1:0] lvl;
    lvl = '0;
    for (int b = 0; b < ADDR_W; b++) begin
      if (pos[b]) lvl = ($clog2(ADDR_W))'(b);
    end
    return ~lvl[0];
  endfunction

  // a wins over b in the given direction
  function automatic logic beats(input logic [PRIO_W-1:0] a, input logic [PRIO_W-1:0] b,
                                 input logic maxdir);
    return maxdir ? (a > b) : (a < b);
  endfunction

endpackage

@@ design/mmhpq_ram.sv @@
// ----------------------------------------------------------------------------
// mmhpq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mmhpq_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // read port
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

@@ design/mmhpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// mmhpq_ctrl
// Sequencer that runs bubble-up, pop and trickle-down over the heap memory.
// ----------------------------------------------------------------------------
module mmhpq_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  mmhpq_pkg::req_t              req,
  output logic                         busy,
  output logic                         done,
  output mmhpq_pkg::rsp_t              rsp,
  output mmhpq_pkg::mem_cmd_t          mem_cmd,
  input  mmhpq_pkg::entry_t            rdata
);

  mmhpq_pkg::state_t state, state_next;

  logic [mmhpq_pkg::COUNT_W-1:0] count, count_next;
  logic [mmhpq_pkg::ADDR_W-1:0]  hole, hole_next;
  logic [mmhpq_pkg::ADDR_W-1:0]  idx, idx_next;
  logic [mmhpq_pkg::ADDR_W-1:0]  pend_addr, pend_addr_next;
  logic [mmhpq_pkg::ADDR_W-1:0]  best_addr, best_addr_next;
  mmhpq_pkg::entry_t             cur, cur_next;
  mmhpq_pkg::entry_t             best, best_next;
  mmhpq_pkg::entry_t             popped, popped_next;
  logic                          maxdir, maxdir_next;
  logic                          pend, pend_next;
  logic                          best_valid, best_valid_next;
  logic [2:0]                    k, k_next;
  logic [1:0]                    status, status_next;
  logic [mmhpq_pkg::PRIO_W-1:0]  mn, mn_next, mx, mx_next;

  // shared decisions
  logic [mmhpq_pkg::CAND_W-1:0]  hx, cand;
  logic                          cand_ok;
  logic                          full, td_win, td_child, up_swap, mlvl;
  logic                          gp_zero, up_g_beats, td_par_swap, pop_trickle;
  logic [mmhpq_pkg::COUNT_W-1:0] count_dec;

  always_comb begin
    hx = mmhpq_pkg::CAND_W'(hole);
    case (k)
      3'd0:    cand = hx << 1;
      3'd1:    cand = (hx << 1) | mmhpq_pkg::CAND_W'(1);
      3'd2:    cand = hx << 2;
      3'd3:    cand = (hx << 2) | mmhpq_pkg::CAND_W'(1);
      3'd4:    cand = (hx << 2) | mmhpq_pkg::CAND_W'(2);
      3'd5:    cand = (hx << 2) | mmhpq_pkg::CAND_W'(3);
      default: cand = '0;
    endcase
    cand_ok     = (k < 3'(mmhpq_pkg::NUM_CAND)) && (cand <= mmhpq_pkg::CAND_W'(count));
    full        = count >= mmhpq_pkg::COUNT_W'(mmhpq_pkg::CAPACITY);
    td_win      = best_valid && mmhpq_pkg::beats(best.prio, cur.prio, maxdir);
    td_child    = {1'b0, best_addr} <= {hole, 1'b1};
    mlvl        = mmhpq_pkg::on_min_level(hole);
    up_swap     = mlvl ? (cur.prio > rdata.prio) : (cur.prio < rdata.prio);
    gp_zero     = (hole >> 2) == '0;
    up_g_beats  = mmhpq_pkg::beats(cur.prio, rdata.prio, maxdir);
    td_par_swap = mmhpq_pkg::beats(rdata.prio, cur.prio, maxdir);
    count_dec   = count - mmhpq_pkg::COUNT_W'(1);
    pop_trickle = mmhpq_pkg::COUNT_W'(idx) <= count_dec;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mmhpq_pkg::S_IDLE: begin
        if (start) begin
          if (req.req_type == mmhpq_pkg::REQ_INSERT) begin
            if (full) state_next = mmhpq_pkg::S_FIN;
            else if (count == '0) state_next = mmhpq_pkg::S_WR_FIN;
            else state_next = mmhpq_pkg::S_UP_PAR;
          end else if (req.req_type == mmhpq_pkg::REQ_POP_MIN ||
                       req.req_type == mmhpq_pkg::REQ_POP_MAX) begin
            if (count == '0) state_next = mmhpq_pkg::S_FIN;
            else if (req.req_type == mmhpq_pkg::REQ_POP_MIN || count == 1)
              state_next = mmhpq_pkg::S_POP_TAKE;
            else state_next = mmhpq_pkg::S_POP_M2;
          end else begin
            state_next = mmhpq_pkg::S_FIN;
          end
        end
      end
      mmhpq_pkg::S_UP_PAR:   state_next = mmhpq_pkg::S_UP_GP;
      mmhpq_pkg::S_UP_GP:    state_next = gp_zero ? mmhpq_pkg::S_WR_FIN : mmhpq_pkg::S_UP_GC;
      mmhpq_pkg::S_UP_GC:    state_next = up_g_beats ? mmhpq_pkg::S_UP_GP : mmhpq_pkg::S_WR_FIN;
      mmhpq_pkg::S_WR_FIN:   state_next = mmhpq_pkg::S_FIN;
      mmhpq_pkg::S_POP_M2:   state_next = (count >= 3) ? mmhpq_pkg::S_POP_M3
                                                       : mmhpq_pkg::S_POP_LAST;
      mmhpq_pkg::S_POP_M3:   state_next = mmhpq_pkg::S_POP_LAST;
      mmhpq_pkg::S_POP_TAKE: state_next = mmhpq_pkg::S_POP_LAST;
      mmhpq_pkg::S_POP_LAST: state_next = pop_trickle ? mmhpq_pkg::S_TD_SCAN : mmhpq_pkg::S_FIN;
      mmhpq_pkg::S_TD_SCAN:  state_next = cand_ok ? mmhpq_pkg::S_TD_SCAN : mmhpq_pkg::S_TD_DEC;
      mmhpq_pkg::S_TD_DEC: begin
        if (!td_win) state_next = mmhpq_pkg::S_FIN;
        else if (td_child) state_next = mmhpq_pkg::S_WR_FIN;
        else state_next = mmhpq_pkg::S_TD_PAR;
      end
      mmhpq_pkg::S_TD_PAR:   state_next = mmhpq_pkg::S_TD_SCAN;
      mmhpq_pkg::S_FIN:      state_next = (count != '0) ? mmhpq_pkg::S_F1 : mmhpq_pkg::S_RES;
      mmhpq_pkg::S_F1:       state_next = (count >= 2) ? mmhpq_pkg::S_F2 : mmhpq_pkg::S_RES;
      mmhpq_pkg::S_F2:       state_next = (count >= 3) ? mmhpq_pkg::S_F3 : mmhpq_pkg::S_RES;
      mmhpq_pkg::S_F3:       state_next = mmhpq_pkg::S_RES;
      mmhpq_pkg::S_RES:      state_next = mmhpq_pkg::S_IDLE;
      default:               state_next = mmhpq_pkg::S_IDLE;
    endcase
  end

  // datapath and memory commands
  always_comb begin
    count_next      = count;
    hole_next       = hole;
    idx_next        = idx;
    pend_addr_next  = pend_addr;
    best_addr_next  = best_addr;
    cur_next        = cur;
    best_next       = best;
    popped_next     = popped;
    maxdir_next     = maxdir;
    pend_next       = pend;
    best_valid_next = best_valid;
    k_next          = k;
    status_next     = status;
    mn_next         = mn;
    mx_next         = mx;
    mem_cmd         = '0;
    mem_cmd.wdata   = cur;
    unique case (state)
      mmhpq_pkg::S_IDLE: begin
        if (start) begin
          status_next = mmhpq_pkg::ST_DONE;
          popped_next = '0;
          cur_next    = '{prio: req.priority_req, tag: req.tag};
          if (req.req_type == mmhpq_pkg::REQ_INSERT) begin
            if (full) begin
              status_next = mmhpq_pkg::ST_FULL;
            end else begin
              count_next    = count + mmhpq_pkg::COUNT_W'(1);
              hole_next     = mmhpq_pkg::ADDR_W'(count + mmhpq_pkg::COUNT_W'(1));
              mem_cmd.re    = 1'b1;
              mem_cmd.raddr = mmhpq_pkg::ADDR_W'((count + mmhpq_pkg::COUNT_W'(1)) >> 1);
            end
          end else if (req.req_type == mmhpq_pkg::REQ_POP_MIN ||
                       req.req_type == mmhpq_pkg::REQ_POP_MAX) begin
            if (count == '0) begin
              status_next = mmhpq_pkg::ST_EMPTY;
            end else if (req.req_type == mmhpq_pkg::REQ_POP_MIN || count == 1) begin
              idx_next      = mmhpq_pkg::ADDR_W'(1);
              mem_cmd.re    = 1'b1;
              mem_cmd.raddr = mmhpq_pkg::ADDR_W'(1);
            end else begin
              mem_cmd.re    = 1'b1;
              mem_cmd.raddr = mmhpq_pkg::ADDR_W'(2);
            end
          end
        end
      end
      // parent compare decides which level kind to climb
      mmhpq_pkg::S_UP_PAR: begin
        if (up_swap) begin
          mem_cmd.we    = 1'b1;
          mem_cmd.waddr = hole;
          mem_cmd.wdata = rdata;
          hole_next     = hole >> 1;
          maxdir_next   = mlvl;
        end else begin
          maxdir_next   = ~mlvl;
        end
      end
      mmhpq_pkg::S_UP_GP: begin
        if (!gp_zero) begin
          mem_cmd.re    = 1'b1;
          mem_cmd.raddr = hole >> 2;
        end
      end
      mmhpq_pkg::S_UP_GC: begin
        if (up_g_beats) begin
          mem_cmd.we    = 1'b1;
          mem_cmd.waddr = hole;
          mem_cmd.wdata = rdata;
          hole_next     = hole >> 2;
        end
      end
      mmhpq_pkg::S_WR_FIN: begin
        mem_cmd.we    = 1'b1;
        mem_cmd.waddr = hole;
      end
      // pop-max picks the larger of positions 2 and 3
      mmhpq_pkg::S_POP_M2: begin
        best_next  = rdata;
        mem_cmd.re = 1'b1;
        if (count >= 3) begin
          mem_cmd.raddr = mmhpq_pkg::ADDR_W'(3);
        end else begin
          idx_next      = mmhpq_pkg::ADDR_W'(2);
          popped_next   = rdata;
          mem_cmd.raddr = mmhpq_pkg::ADDR_W'(count);
        end
      end
      mmhpq_pkg::S_POP_M3: begin
        if (best.prio < rdata.prio) begin
          idx_next    = mmhpq_pkg::ADDR_W'(3);
          popped_next = rdata;
        end else begin
          idx_next    = mmhpq_pkg::ADDR_W'(2);
          popped_next = best;
        end
        mem_cmd.re    = 1'b1;
        mem_cmd.raddr = mmhpq_pkg::ADDR_W'(count);
      end
      mmhpq_pkg::S_POP_TAKE: begin
        popped_next   = rdata;
        mem_cmd.re    = 1'b1;
        mem_cmd.raddr = mmhpq_pkg::ADDR_W'(count);
      end
      // last entry fills the hole
      mmhpq_pkg::S_POP_LAST: begin
        cur_next        = rdata;
        count_next      = count_dec;
        hole_next       = idx;
        maxdir_next     = ~mmhpq_pkg::on_min_level(idx);
        k_next          = '0;
        pend_next       = 1'b0;
        best_valid_next = 1'b0;
      end
      // scan children then grandchildren, one read per cycle
      mmhpq_pkg::S_TD_SCAN: begin
        if (pend && (!best_valid || mmhpq_pkg::beats(rdata.prio, best.prio, maxdir))) begin
          best_next       = rdata;
          best_addr_next  = pend_addr;
          best_valid_next = 1'b1;
        end
        pend_next = cand_ok;
        if (cand_ok) begin
          mem_cmd.re     = 1'b1;
          mem_cmd.raddr  = cand[mmhpq_pkg::ADDR_W-1:0];
          pend_addr_next = cand[mmhpq_pkg::ADDR_W-1:0];
          k_next         = k + 3'd1;
        end
      end
      mmhpq_pkg::S_TD_DEC: begin
        mem_cmd.we    = 1'b1;
        mem_cmd.waddr = hole;
        if (td_win) begin
          mem_cmd.wdata = best;
          hole_next     = best_addr;
          if (!td_child) begin
            mem_cmd.re    = 1'b1;
            mem_cmd.raddr = best_addr >> 1;
          end
        end
      end
      // grandchild step: parent of the new hole may swap with the mover
      mmhpq_pkg::S_TD_PAR: begin
        if (td_par_swap) begin
          mem_cmd.we    = 1'b1;
          mem_cmd.waddr = hole >> 1;
          cur_next      = rdata;
        end
        k_next          = '0;
        pend_next       = 1'b0;
        best_valid_next = 1'b0;
      end
      // read the top three positions for min and max
      mmhpq_pkg::S_FIN: begin
        mn_next = '0;
        mx_next = '0;
        if (count != '0) begin
          mem_cmd.re    = 1'b1;
          mem_cmd.raddr = mmhpq_pkg::ADDR_W'(1);
        end
      end
      mmhpq_pkg::S_F1: begin
        mn_next = rdata.prio;
        mx_next = rdata.prio;
        if (count >= 2) begin
          mem_cmd.re    = 1'b1;
          mem_cmd.raddr = mmhpq_pkg::ADDR_W'(2);
        end
      end
      mmhpq_pkg::S_F2: begin
        mx_next = rdata.prio;
        if (count >= 3) begin
          mem_cmd.re    = 1'b1;
          mem_cmd.raddr = mmhpq_pkg::ADDR_W'(3);
        end
      end
      mmhpq_pkg::S_F3: begin
        if (rdata.prio > mx) mx_next = rdata.prio;
      end
      mmhpq_pkg::S_RES: begin
      end
      default: begin
      end
    endcase
  end

  // result word
  always_comb begin
    busy                = state != mmhpq_pkg::S_IDLE;
    done                = state == mmhpq_pkg::S_RES;
    rsp.status          = status;
    rsp.popped_priority = popped.prio;
    rsp.popped_tag      = popped.tag;
    rsp.entry_count     = count;
    rsp.current_min     = mn;
    rsp.current_max     = mx;
    rsp.is_empty        = count == '0;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmhpq_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    hole       <= hole_next;
    idx        <= idx_next;
    pend_addr  <= pend_addr_next;
    best_addr  <= best_addr_next;
    cur        <= cur_next;
    best       <= best_next;
    popped     <= popped_next;
    maxdir     <= maxdir_next;
    pend       <= pend_next;
    best_valid <= best_valid_next;
    k          <= k_next;
    status     <= status_next;
    mn         <= mn_next;
    mx         <= mx_next;
  end

endmodule

@@ design/min_max_heap_priority_queue.sv @@
// ----------------------------------------------------------------------------
// min_max_heap_priority_queue
// Double-ended priority queue on a min-max heap held in one RAM.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result word shows
// on rsp for exactly one cycle with done high and cannot be held off. All heap
// entries live in a single RAM with one read and one write port. An insert
// compares the new entry with its parent and then climbs one grandparent level
// at a time; a pop reads the chosen extreme and the last entry, then trickles
// down, scanning each existing child and grandchild per level. Results carry
// the count and current min and max, read from positions 1 to 3 at the end.
`include "min_max_heap_priority_queue_assert.svh"

module min_max_heap_priority_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  mmhpq_pkg::req_t req,
  output logic            busy,
  output logic            done,
  output mmhpq_pkg::rsp_t rsp
);

  mmhpq_pkg::mem_cmd_t mem_cmd;
  mmhpq_pkg::entry_t   rdata;

  // sequencer
  mmhpq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .req     (req),
    .busy    (busy),
    .done    (done),
    .rsp     (rsp),
    .mem_cmd (mem_cmd),
    .rdata   (rdata)
  );

  // heap storage
  mmhpq_ram #(
    .DATA_W ($bits(mmhpq_pkg::entry_t)),
    .ADDR_W (mmhpq_pkg::ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_cmd.we),
    .waddr (mem_cmd.waddr),
    .wdata (mem_cmd.wdata),
    .re    (mem_cmd.re),
    .raddr (mem_cmd.raddr),
    .rdata (rdata)
  );

  // checks
  `MMHPQ_AST_NEXT(a_done_single, done, !done)
  `MMHPQ_AST_NEXT(a_start_busy, start && !busy, busy)
  `MMHPQ_AST_NOW(a_empty_flag, done, rsp.is_empty == (rsp.entry_count == '0))
  `MMHPQ_AST_NOW(a_full_count, done && rsp.status == mmhpq_pkg::ST_FULL, rsp.entry_count == mmhpq_pkg::COUNT_W'(mmhpq_pkg::CAPACITY))

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the min-max heap priority queue: requests are driven
// through the start/busy handshake, a heap predictor tracks the contents and
// every response word is compared field by field against it.
// ----------------------------------------------------------------------------
module tb_top;

  // heap predictor with a queue of expected response words
  class heap_scoreboard;
    logic [mmhpq_pkg::PRIO_W-1:0] prio_q[mmhpq_pkg::CAPACITY+1];
    logic [mmhpq_pkg::TAG_W-1:0]  tag_q[mmhpq_pkg::CAPACITY+1];
    int                           fill;
    mmhpq_pkg::rsp_t              pending[$];
    int                           errors;
    int                           checked;

    function void swap_pos(int i, int j);
      logic [mmhpq_pkg::PRIO_W-1:0] p;
      logic [mmhpq_pkg::TAG_W-1:0]  t;
      p = prio_q[i]; t = tag_q[i];
      prio_q[i] = prio_q[j]; tag_q[i] = tag_q[j];
      prio_q[j] = p; tag_q[j] = t;
    endfunction

    function bit min_lvl(int i);
      int lvl;
      lvl = 0;
      while (i > 1) begin
        i = i >> 1;
        lvl++;
      end
      return (lvl % 2) == 0;
    endfunction

    function bit wins(int a, int b, bit maxdir);
      return maxdir ? (prio_q[a] > prio_q[b]) : (prio_q[a] < prio_q[b]);
    endfunction

    function void climb(int i, bit maxdir);
      while (i / 4 != 0 && wins(i, i / 4, maxdir)) begin
        swap_pos(i, i / 4);
        i = i / 4;
      end
    endfunction

    function void sift_up(int i);
      bit maxdir;
      if (i / 2 == 0) return;
      maxdir = min_lvl(i);
      if (wins(i, i / 2, maxdir)) begin
        swap_pos(i, i / 2);
        climb(i / 2, maxdir);
      end else begin
        climb(i, !maxdir);
      end
    endfunction

    function void sift_down(int i);
      bit maxdir;
      int m;
      int c;
      int cand[6];
      maxdir = !min_lvl(i);
      forever begin
        cand = '{2*i, 2*i+1, 4*i, 4*i+1, 4*i+2, 4*i+3};
        m = 0;
        for (int k = 0; k < 6; k++) begin
          c = cand[k];
          if (c <= fill && (m == 0 || wins(c, m, maxdir))) m = c;
        end
        if (m == 0 || !wins(m, i, maxdir)) return;
        swap_pos(i, m);
        if (m <= 2*i + 1) return;
        if (wins(m / 2, m, maxdir)) swap_pos(m, m / 2);
        i = m;
      end
    endfunction

    // note an accepted request and queue its expected response
    function void note_request(mmhpq_pkg::req_t r);
      mmhpq_pkg::rsp_t e;
      int              idx;
      e = '0;
      if (r.req_type == mmhpq_pkg::REQ_INSERT) begin
        if (fill >= mmhpq_pkg::CAPACITY) begin
          e.status = mmhpq_pkg::ST_FULL;
        end else begin
          fill++;
          prio_q[fill] = r.priority_req;
          tag_q[fill]  = r.tag;
          sift_up(fill);
        end
      end else if (r.req_type == mmhpq_pkg::REQ_POP_MIN ||
                   r.req_type == mmhpq_pkg::REQ_POP_MAX) begin
        if (fill == 0) begin
          e.status = mmhpq_pkg::ST_EMPTY;
        end else begin
          idx = 1;
          if (r.req_type == mmhpq_pkg::REQ_POP_MAX && fill >= 2) begin
            idx = 2;
            if (fill >= 3 && prio_q[2] < prio_q[3]) idx = 3;
          end
          e.popped_priority = prio_q[idx];
          e.popped_tag      = tag_q[idx];
          prio_q[idx] = prio_q[fill];
          tag_q[idx]  = tag_q[fill];
          fill--;
          if (idx <= fill) sift_down(idx);
        end
      end
      if (fill >= 1) begin
        e.current_min = prio_q[1];
        e.current_max = prio_q[1];
        if (fill >= 2) e.current_max = prio_q[2];
        if (fill >= 3 && prio_q[3] > e.current_max) e.current_max = prio_q[3];
      end
      e.entry_count = fill[mmhpq_pkg::COUNT_W-1:0];
      e.is_empty    = (fill == 0);
      pending.push_back(e);
    endfunction

    // compare one response word with the oldest expectation
    function void check_response(mmhpq_pkg::rsp_t a);
      mmhpq_pkg::rsp_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t unexpected response word %h", $time, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.status !== e.status) begin
        $display("%0t status exp %0d got %0d", $time, e.status, a.status);
        errors++;
      end
      if (a.popped_priority !== e.popped_priority) begin
        $display("%0t popped_priority exp %0d got %0d", $time,
                 e.popped_priority, a.popped_priority);
        errors++;
      end
      if (a.popped_tag !== e.popped_tag) begin
        $display("%0t popped_tag exp %0d got %0d", $time, e.popped_tag, a.popped_tag);
        errors++;
      end
      if (a.entry_count !== e.entry_count) begin
        $display("%0t entry_count exp %0d got %0d", $time, e.entry_count, a.entry_count);
        errors++;
      end
      if (a.current_min !== e.current_min) begin
        $display("%0t current_min exp %0d got %0d", $time, e.current_min, a.current_min);
        errors++;
      end
      if (a.current_max !== e.current_max) begin
        $display("%0t current_max exp %0d got %0d", $time, e.current_max, a.current_max);
        errors++;
      end
      if (a.is_empty !== e.is_empty) begin
        $display("%0t is_empty exp %0d got %0d", $time, e.is_empty, a.is_empty);
        errors++;
      end
    endfunction
  endclass

  logic            clk;
  logic            rst;
  logic            start;
  mmhpq_pkg::req_t req;
  logic            busy;
  logic            done;
  mmhpq_pkg::rsp_t rsp;

  heap_scoreboard sb;
  int  idle_cycles;
  int  sent;
  int  max_fill;
  bit  quiet;

  min_max_heap_priority_queue DUT (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .req  (req),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // response checking and stall watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_response(rsp);
      if (done || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("watchdog expired");
        $display("FAIL");
        $finish;
      end
    end
  end

  // drive one request and hold it until accepted, with random gaps
  task automatic send_request(logic [1:0] kind, logic [mmhpq_pkg::PRIO_W-1:0] p,
                              logic [mmhpq_pkg::TAG_W-1:0] t);
    while (!quiet && $urandom_range(99) < 22) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req   <= '{req_type: kind, priority_req: p, tag: t};
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(req);
    sent++;
    if (sb.fill > max_fill) max_fill = sb.fill;
  endtask

  task automatic drain_responses();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [mmhpq_pkg::PRIO_W-1:0] rand_prio();
    case ($urandom_range(3))
      0: return mmhpq_pkg::PRIO_W'($urandom_range(15));
      1: return mmhpq_pkg::PRIO_W'($urandom);
      2: return mmhpq_pkg::PRIO_W'(32'h7FFF_FFFF - $urandom_range(3));
      default: return mmhpq_pkg::PRIO_W'($urandom_range(1000));
    endcase
  endfunction

  initial begin
    logic [1:0] kind;
    int r;
    sb = new();
    start = 1'b0;
    req = '0;
    rst = 1'b1;
    idle_cycles = 0;
    sent = 0;
    max_fill = 0;
    quiet = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: pops on empty, extremes, ties, unused code
    send_request(mmhpq_pkg::REQ_POP_MIN, 31'h7FFF_FFFF, 16'hFFFF);
    send_request(mmhpq_pkg::REQ_POP_MAX, 0, 0);
    send_request(mmhpq_pkg::REQ_UNUSED, 31'h5555_5555, 16'hAAAA);
    send_request(mmhpq_pkg::REQ_INSERT, 31'h7FFF_FFFF, 16'hFFFF);
    send_request(mmhpq_pkg::REQ_INSERT, 0, 0);
    send_request(mmhpq_pkg::REQ_POP_MAX, 0, 0);
    send_request(mmhpq_pkg::REQ_INSERT, 31'h2AAA_AAAA, 16'h5555);
    send_request(mmhpq_pkg::REQ_INSERT, 31'h5555_5555, 16'hAAAA);
    send_request(mmhpq_pkg::REQ_INSERT, 31'h5555_5555, 16'h1234);
    for (int i = 0; i < 8; i++) send_request(mmhpq_pkg::REQ_INSERT, 7, mmhpq_pkg::TAG_W'(i));
    send_request(mmhpq_pkg::REQ_UNUSED, 0, 0);
    for (int i = 0; i < 5; i++) send_request(mmhpq_pkg::REQ_POP_MIN, 0, 0);
    for (int i = 0; i < 6; i++) send_request(mmhpq_pkg::REQ_POP_MAX, 0, 0);
    send_request(mmhpq_pkg::REQ_POP_MIN, 0, 0);

    // pause the sender until all responses are back
    drain_responses();

    // build a deep heap without gaps
    quiet = 1;
    for (int i = 0; i < 300; i++)
      send_request(mmhpq_pkg::REQ_INSERT, rand_prio(), mmhpq_pkg::TAG_W'($urandom));
    quiet = 0;

    // random mixes; bias toward pops, then toward inserts
    for (int i = 0; i < 370; i++) begin
      r = $urandom_range(99);
      if (i < 185) kind = (r < 30) ? mmhpq_pkg::REQ_INSERT
                        : (r < 64) ? mmhpq_pkg::REQ_POP_MIN
                        : (r < 97) ? mmhpq_pkg::REQ_POP_MAX : mmhpq_pkg::REQ_UNUSED;
      else kind = (r < 60) ? mmhpq_pkg::REQ_INSERT
                : (r < 79) ? mmhpq_pkg::REQ_POP_MIN
                : (r < 98) ? mmhpq_pkg::REQ_POP_MAX : mmhpq_pkg::REQ_UNUSED;
      send_request(kind, rand_prio(), mmhpq_pkg::TAG_W'($urandom));
    end

    drain_responses();
    $display("sent %0d requests, checked %0d responses, peak fill %0d of %0d",
             sent, sb.checked, max_fill, mmhpq_pkg::CAPACITY);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

@@ min_max_heap_priority_queue.f @@
+incdir+design
design/mmhpq_pkg.sv
design/mmhpq_ram.sv
design/mmhpq_ctrl.sv
design/min_max_heap_priority_queue.sv
verif/tb_top.sv
